>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the card number check RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check expr at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// check cons in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// check cons in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

>>> design/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg
// Types, constants and Luhn helper functions for the card number check.
// ----------------------------------------------------------------------------
package cnlc_pkg;

   localparam int DIGIT_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   localparam logic [COUNT_W-1:0] LEN_MIN   = 5'd13;
   localparam logic [COUNT_W-1:0] LEN_MAX   = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 5'd17;

   localparam logic [DIGIT_W-1:0] PREFIX_FOUR   = 4'd4;
   localparam logic [DIGIT_W-1:0] PREFIX_FIVE   = 4'd5;
   localparam logic [DIGIT_W-1:0] PREFIX_SIX    = 4'd6;
   localparam logic [DIGIT_W-1:0] PREFIX_THREE  = 4'd3;
   localparam logic [DIGIT_W-1:0] PREFIX_SEVEN  = 4'd7;

   localparam logic [STATUS_W-1:0] STATUS_VALID    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_LENGTH   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_PREFIX   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CHECKSUM = 3'd4;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } cnlc_word_type;

   typedef struct packed {
      logic               nonzero;
      logic [COUNT_W-1:0] count;
      logic [DIGIT_W-1:0] lead;
      logic [DIGIT_W-1:0] second;
      logic [DIGIT_W-1:0] sum_plain;
   } cnlc_summary_type;

   function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] a,
                                                    input logic [DIGIT_W-1:0] b);
      logic [DIGIT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 5'd10) begin
         s = s - 5'd10;
      end
      return s[DIGIT_W-1:0];
   endfunction

   function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W:0] t;
      t = {d, 1'b0};
      if (t > 5'd9) begin
         t = t - 5'd9;
      end
      return t[DIGIT_W-1:0];
   endfunction

endpackage

>>> design/cnlc_stream_if.sv
// ----------------------------------------------------------------------------
// cnlc_stream_if
// Valid/ready channels for digit words and verdict words.
// ----------------------------------------------------------------------------
interface cnlc_req_if;
   import cnlc_pkg::*;

   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last;

   modport source (output valid, output digit, output last, input ready);
   modport sink   (input valid, input digit, input last, output ready);
endinterface

interface cnlc_rsp_if;
   import cnlc_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  digit_count;

   modport source (output valid, output status, output digit_count, input ready);
   modport sink   (input valid, input status, input digit_count, output ready);
endinterface

>>> design/cnlc_in_stage.sv
// ----------------------------------------------------------------------------
// cnlc_in_stage
// Input register for digit words with pass-through ready.
// ----------------------------------------------------------------------------
module cnlc_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   cnlc_req_if.sink               req_port,
   input  logic                   out_free,
   output logic                   word_valid,
   output cnlc_pkg::cnlc_word_type word
);
   import cnlc_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   cnlc_word_type word_ff;
   cnlc_word_type word_in;

   assign req_port.ready = !valid_ff || out_free;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (req_port.ready) begin
         valid_in = req_port.valid;
      end
      if (req_port.ready && req_port.valid) begin
         word_in.digit = req_port.digit;
         word_in.last  = req_port.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

>>> design/cnlc_accum.sv
// ----------------------------------------------------------------------------
// cnlc_accum
// Running digit count, prefix capture and dual-parity Luhn sums.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnlc_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  cnlc_pkg::cnlc_word_type   word,
   output cnlc_pkg::cnlc_summary_type summary
);
   import cnlc_pkg::*;

   logic               nonzero_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [DIGIT_W-1:0] lead_ff;
   logic [DIGIT_W-1:0] second_ff;
   logic [DIGIT_W-1:0] plain_ff;
   logic [DIGIT_W-1:0] doubled_ff;

   logic               nonzero_in;
   logic [COUNT_W-1:0] count_in;
   logic [DIGIT_W-1:0] lead_in;
   logic [DIGIT_W-1:0] second_in;
   logic [DIGIT_W-1:0] plain_in;
   logic [DIGIT_W-1:0] doubled_in;

   logic [DIGIT_W-1:0] digit_sat;

   always_comb begin
      digit_sat  = (word.digit > DIGIT_MAX) ? DIGIT_MAX : word.digit;
      nonzero_in = nonzero_ff;
      count_in   = count_ff;
      lead_in    = lead_ff;
      second_in  = second_ff;
      plain_in   = plain_ff;
      doubled_in = doubled_ff;
      if (nonzero_ff || digit_sat != '0) begin
         if (count_ff == 5'd0) begin
            lead_in = digit_sat;
         end else if (count_ff == 5'd1) begin
            second_in = digit_sat;
         end
         if (count_ff < COUNT_SAT) begin
            count_in = count_ff + 5'd1;
         end
         nonzero_in = 1'b1;
         plain_in   = add_mod10(doubled_ff, digit_sat);
         doubled_in = add_mod10(plain_ff, luhn_double(digit_sat));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonzero_ff <= 1'b0;
         count_ff   <= '0;
         lead_ff    <= '0;
         second_ff  <= '0;
         plain_ff   <= '0;
         doubled_ff <= '0;
      end else if (advance) begin
         if (word.last) begin
            nonzero_ff <= 1'b0;
            count_ff   <= '0;
            lead_ff    <= '0;
            second_ff  <= '0;
            plain_ff   <= '0;
            doubled_ff <= '0;
         end else begin
            nonzero_ff <= nonzero_in;
            count_ff   <= count_in;
            lead_ff    <= lead_in;
            second_ff  <= second_in;
            plain_ff   <= plain_in;
            doubled_ff <= doubled_in;
         end
      end
   end

   assign summary.nonzero   = nonzero_in;
   assign summary.count     = count_in;
   assign summary.lead      = lead_in;
   assign summary.second    = second_in;
   assign summary.sum_plain = plain_in;

   `ASSERT_ALWAYS(a_count_sat, clock, reset, count_ff <= COUNT_SAT)
   `ASSERT_ALWAYS(a_zero_idle, clock, reset, nonzero_ff || (count_ff == '0 && plain_ff == '0))
   `ASSERT_NEXT(a_clear_on_last, clock, reset, advance && word.last, !nonzero_ff && count_ff == '0)

endmodule

>>> design/cnlc_verdict.sv
// ----------------------------------------------------------------------------
// cnlc_verdict
// Verdict decode and result register for the verdict channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnlc_verdict (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       emit,
   input  cnlc_pkg::cnlc_summary_type summary,
   cnlc_rsp_if.source                 rsp_port,
   output logic                       out_free
);
   import cnlc_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [COUNT_W-1:0]  count_ff;
   logic                prefix_ok;

   assign out_free = !valid_ff || rsp_port.ready;

   always_comb begin
      prefix_ok = summary.lead == PREFIX_FOUR || summary.lead == PREFIX_FIVE ||
                  summary.lead == PREFIX_SIX ||
                  (summary.lead == PREFIX_THREE && summary.second == PREFIX_SEVEN);
      priority if (!summary.nonzero) begin
         status_in = STATUS_ZERO;
      end else if (summary.count < LEN_MIN || summary.count > LEN_MAX) begin
         status_in = STATUS_LENGTH;
      end else if (!prefix_ok) begin
         status_in = STATUS_PREFIX;
      end else if (summary.sum_plain != '0) begin
         status_in = STATUS_CHECKSUM;
      end else begin
         status_in = STATUS_VALID;
      end
      valid_in = out_free ? emit : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit) begin
         status_ff <= status_in;
         count_ff  <= summary.count;
      end
   end

   assign rsp_port.valid       = valid_ff;
   assign rsp_port.status      = status_ff;
   assign rsp_port.digit_count = count_ff;

   `ASSERT_IMPLY(a_valid_len, clock, reset, valid_ff && status_ff == STATUS_VALID, count_ff >= LEN_MIN && count_ff <= LEN_MAX)
   `ASSERT_IMPLY(a_zero_count, clock, reset, valid_ff && status_ff == STATUS_ZERO, count_ff == '0)

endmodule

>>> design/card_number_luhn_check.sv
// ----------------------------------------------------------------------------
// card_number_luhn_check
// Luhn mod-10 card number check over a stream of decimal digits.
// Path: single input register, then single result register for the verdict.
// Throughput: one digit per cycle unless the verdict channel stalls.
// Reset: synchronous; clears the digit count, prefix, sums and both valids.
// ----------------------------------------------------------------------------
module card_number_luhn_check (
   input  logic        clock,
   input  logic        reset,
   cnlc_req_if.sink    req_port,
   cnlc_rsp_if.source  rsp_port
);
   import cnlc_pkg::*;

   logic             out_free;
   logic             word_valid;
   logic             advance;
   cnlc_word_type    word;
   cnlc_summary_type summary;

   assign advance = word_valid && out_free;

   cnlc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .out_free   (out_free),
      .word_valid (word_valid),
      .word       (word)
   );

   cnlc_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (word),
      .summary (summary)
   );

   cnlc_verdict u_verdict (
      .clock    (clock),
      .reset    (reset),
      .emit     (advance && word.last),
      .summary  (summary),
      .rsp_port (rsp_port),
      .out_free (out_free)
   );

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives card numbers digit by digit into the Luhn card number check, with
// random gaps and response stalls, and compares every verdict word against a
// cycle-free predictor of the digit count, prefix and mod-10 sums.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cnlc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  digit_count;
   } verdict_type;

   logic clock;
   logic reset;

   cnlc_req_if req_chan();
   cnlc_rsp_if rsp_chan();

   card_number_luhn_check i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan.sink),
      .rsp_port (rsp_chan.source)
   );

   verdict_type        verdict_queue[$];
   logic [DIGIT_W-1:0] card_digits[$];
   int                 error_count = 0;
   int                 words_sent  = 0;
   bit                 steady_flow = 1'b0;

   logic               seen_nonzero;
   logic [COUNT_W-1:0] sig_count;
   logic [DIGIT_W-1:0] first_digit;
   logic [DIGIT_W-1:0] second_digit;
   logic [DIGIT_W-1:0] sum_plain;
   logic [DIGIT_W-1:0] sum_doubled;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (steady_flow) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [DIGIT_W-1:0] luhn_fold(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W:0] t;
      t = {d, 1'b0};
      if (t > 5'd9) begin
         t = t - 5'd9;
      end
      return t[DIGIT_W-1:0];
   endfunction

   task automatic clear_card_state();
      seen_nonzero = 1'b0;
      sig_count    = '0;
      first_digit  = '0;
      second_digit = '0;
      sum_plain    = '0;
      sum_doubled  = '0;
   endtask

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t ns: %s", $time, what);
   endtask

   task automatic track_digit(input logic [DIGIT_W-1:0] raw, input logic last);
      logic [DIGIT_W-1:0] d;
      logic [DIGIT_W-1:0] next_plain;
      verdict_type        v;
      d = (raw > DIGIT_MAX) ? DIGIT_MAX : raw;
      if (seen_nonzero || d != 4'd0) begin
         if (sig_count == 5'd0) begin
            first_digit = d;
         end else if (sig_count == 5'd1) begin
            second_digit = d;
         end
         if (sig_count < COUNT_SAT) begin
            sig_count = sig_count + 5'd1;
         end
         seen_nonzero = 1'b1;
         next_plain   = DIGIT_W'((int'(sum_doubled) + int'(d)) % 10);
         sum_doubled  = DIGIT_W'((int'(sum_plain) + int'(luhn_fold(d))) % 10);
         sum_plain    = next_plain;
      end
      if (last) begin
         v.digit_count = sig_count;
         if (!seen_nonzero) begin
            v.status = STATUS_ZERO;
         end else if (sig_count < LEN_MIN || sig_count > LEN_MAX) begin
            v.status = STATUS_LENGTH;
         end else if (!(first_digit == PREFIX_FOUR || first_digit == PREFIX_FIVE ||
                        first_digit == PREFIX_SIX ||
                        (first_digit == PREFIX_THREE && second_digit == PREFIX_SEVEN))) begin
            v.status = STATUS_PREFIX;
         end else if (sum_plain != 4'd0) begin
            v.status = STATUS_CHECKSUM;
         end else begin
            v.status = STATUS_VALID;
         end
         verdict_queue = {verdict_queue, v};
         clear_card_state();
      end
   endtask

   task automatic send_word(input logic [DIGIT_W-1:0] digit, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.digit <= digit;
      req_chan.last  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      words_sent++;
      track_digit(digit, last);
   endtask

   task automatic send_card();
      int i;
      for (i = 0; i < card_digits.size(); i++) begin
         send_word(card_digits[i], i == card_digits.size() - 1);
      end
   endtask

   task automatic wait_for_verdicts();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (verdict_queue.size() != 0) @(posedge clock);
   endtask

   task automatic build_card(input bit well_formed);
      int                 len;
      int                 lead_zeros;
      int                 i;
      int                 sum;
      int                 pick;
      logic [DIGIT_W-1:0] wide;
      logic [DIGIT_W-1:0] eff[$];
      card_digits.delete();
      if (!well_formed) begin
         len  = $urandom_range(1, 20);
         pick = $urandom_range(0, 7);
         for (i = 0; i < len; i++) begin
            wide = DIGIT_W'($urandom_range(0, 15));
            if (pick == 0 || $urandom_range(0, 3) == 0) begin
               wide = '0;
            end
            card_digits = {card_digits, wide};
         end
         return;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         len = $urandom_range(13, 16);
      end else if (pick == 7) begin
         len = $urandom_range(0, 1) ? 12 : 17;
      end else if (pick == 8) begin
         len = $urandom_range(1, 11);
      end else begin
         len = $urandom_range(18, 24);
      end
      pick = $urandom_range(0, 7);
      case (pick)
         0: eff = {eff, PREFIX_FOUR};
         1: eff = {eff, PREFIX_FIVE};
         2: eff = {eff, PREFIX_SIX};
         3, 4: eff = {eff, PREFIX_THREE};
         default: begin
            wide = DIGIT_W'($urandom_range(1, 9));
            eff = {eff, wide};
         end
      endcase
      for (i = 1; i < len; i++) begin
         wide = DIGIT_W'($urandom_range(0, 9));
         eff = {eff, wide};
      end
      if (len > 1 && pick == 3) begin
         eff[1] = PREFIX_SEVEN;
      end
      // when len > 1, usually pick the final digit so the mod-10 sum closes
      if (len > 1 && $urandom_range(0, 9) < 7) begin
         sum = 0;
         for (i = 0; i < len - 1; i++) begin
            sum += ((len - 1 - i) % 2 != 0) ? int'(luhn_fold(eff[i])) : int'(eff[i]);
         end
         eff[len-1] = DIGIT_W'((10 - sum % 10) % 10);
      end
      lead_zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (lead_zeros) card_digits = {card_digits, 4'd0};
      for (i = 0; i < len; i++) begin
         wide = eff[i];
         if (wide == DIGIT_MAX && $urandom_range(0, 3) == 0) begin
            wide = DIGIT_W'($urandom_range(10, 15));
         end
         card_digits = {card_digits, wide};
      end
   endtask

   task automatic test_zero_number();
      send_word(4'd0, 1'b1);
      send_word(4'd0, 1'b0);
      send_word(4'd0, 1'b0);
      send_word(4'd0, 1'b1);
   endtask

   task automatic test_short_numbers();
      send_word(4'd15, 1'b1);
      send_word(PREFIX_THREE, 1'b0);
      send_word(PREFIX_SEVEN, 1'b1);
   endtask

   task automatic test_valid_card();
      logic [DIGIT_W-1:0] card [14] = '{4'd0, 4'd4, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
                                        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd15};
      int i;
      for (i = 0; i < 14; i++) begin
         send_word(card[i], i == 13);
      end
   endtask

   task automatic test_random_cards(input int word_total);
      int first;
      first = words_sent;
      while (words_sent - first < word_total) begin
         build_card($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 24) == 0) begin
            wait_for_verdicts();
         end
         send_card();
      end
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      test_random_cards(150);
      steady_flow = 1'b0;
   endtask

   task automatic test_drain_pause();
      repeat (4) begin
         build_card(1'b1);
         wait_for_verdicts();
         send_card();
      end
   endtask

   initial begin : verdict_checker
      int          stall_left;
      verdict_type want;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected verdict status %0d count %0d",
                                         rsp_chan.status, rsp_chan.digit_count));
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_chan.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, want %0d",
                                            rsp_chan.status, want.status));
               end
               if (rsp_chan.digit_count !== want.digit_count) begin
                  report_mismatch($sformatf("digit_count %0d, want %0d",
                                            rsp_chan.digit_count, want.digit_count));
               end
            end
         end
         if (steady_flow) begin
            stall_left = 0;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.digit <= '0;
      req_chan.last  <= 1'b0;
      clear_card_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_zero_number();
      test_short_numbers();
      test_valid_card();
      test_random_cards(600);
      test_steady_stream();
      test_drain_pause();
      test_random_cards(500);

      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/cnlc_pkg.sv
design/cnlc_stream_if.sv
design/cnlc_in_stage.sv
design/cnlc_accum.sv
design/cnlc_verdict.sv
design/card_number_luhn_check.sv
dv/testbench.sv
